FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the frame decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, written for a block that uses the house clock and reset names.
`define MFD_ASSERT_STD(lbl, prop, msg) \
  `MFD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback decoder package
// Frame kinds, register indexes, field widths and the per-frame info record.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned VALUE_W = 21;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned IDENT_W = 29;
  localparam int unsigned SENDER_W = 11;

  localparam logic [1:0] KIND_INVALID  = 2'd0;
  localparam logic [1:0] KIND_FOREIGN  = 2'd1;
  localparam logic [1:0] KIND_FEEDBACK = 2'd2;

  localparam logic [2:0] CFG_SENDER_ID = 3'd0;
  localparam logic [2:0] CFG_MOTOR_NUM = 3'd1;
  localparam logic [2:0] CFG_POS_LIMIT = 3'd2;
  localparam logic [2:0] CFG_VEL_LIMIT = 3'd3;
  localparam logic [2:0] CFG_TRQ_LIMIT = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       status;
    logic [7:0]       drv_temp;
    logic [7:0]       wnd_temp;
    logic [CNT_W-1:0] time_ms;
  } mfd_frame_t;

endpackage

`default_nettype wire

FILE: hdl/mfd_scale.sv
// ----------------------------------------------------------------------------
// Code scaler
// Registers code * 2 * limit + full / 2, then divides by 2^BITS - 1 by
// repeated folding of the high digit and subtracts the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_scale
  import mfd_pkg::*;
#(
  parameter int unsigned BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire logic [BITS-1:0]           code_i,
  input  wire logic [LIMIT_W-1:0]        limit_i,
  output logic signed [VALUE_W-1:0]      value_o
);

  localparam int unsigned NW    = BITS + LIMIT_W + 1;
  localparam int unsigned NFOLD = (NW + BITS - 2) / (BITS - 1) + 1;
  localparam logic [NW-1:0] FULL = NW'((64'd1 << BITS) - 64'd1);
  localparam logic [NW-1:0] HALF = NW'(((64'd1 << BITS) - 64'd1) / 64'd2);

  logic [NW-1:0]      num_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [NW-1:0]      rem;
  logic [NW-1:0]      quot;
  logic [NW-1:0]      hi;
  logic signed [VALUE_W:0] diff;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q   <= NW'(code_i) * NW'({limit_i, 1'b0}) + HALF;
      limit_q <= limit_i;
    end
  end

  // Since 2^BITS = FULL + 1, each fold moves the high digit into the quotient
  // and adds it back to the remainder.
  always_comb begin
    rem  = num_q;
    quot = '0;
    hi   = '0;
    for (int i = 0; i < NFOLD; i++) begin
      hi   = rem >> BITS;
      rem  = hi + (rem & FULL);
      quot = quot + hi;
    end
    if (rem >= FULL) begin
      quot = quot + NW'(1);
    end
    diff    = $signed(quot[VALUE_W:0]) - $signed({2'b00, limit_q});
    value_o = diff[VALUE_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hdl/mfd_state.sv
// ----------------------------------------------------------------------------
// Feedback state
// Holds the last decoded feedback, its arrival time and the frame counters.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mfd_state
  import mfd_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      upd_i,
  input  wire mfd_frame_t                frame_i,
  input  wire logic signed [VALUE_W-1:0] pos_i,
  input  wire logic signed [VALUE_W-1:0] vel_i,
  input  wire logic signed [VALUE_W-1:0] trq_i,
  output logic                           have_feedback_o,
  output logic [3:0]                     status_o,
  output logic signed [VALUE_W-1:0]      pos_o,
  output logic signed [VALUE_W-1:0]      vel_o,
  output logic signed [VALUE_W-1:0]      trq_o,
  output logic [7:0]                     drv_temp_o,
  output logic [7:0]                     wnd_temp_o,
  output logic [CNT_W-1:0]               time_o,
  output logic [CNT_W-1:0]               good_o,
  output logic [CNT_W-1:0]               bad_o
);

  logic                      valid_q;
  logic [3:0]                status_q;
  logic signed [VALUE_W-1:0] pos_q;
  logic signed [VALUE_W-1:0] vel_q;
  logic signed [VALUE_W-1:0] trq_q;
  logic [7:0]                drv_q;
  logic [7:0]                wnd_q;
  logic [CNT_W-1:0]          time_q;
  logic [CNT_W-1:0]          good_q;
  logic [CNT_W-1:0]          bad_q;
  logic                      take_fb;
  logic                      take_bad;

  assign take_fb  = upd_i && (frame_i.kind == KIND_FEEDBACK);
  assign take_bad = upd_i && (frame_i.kind == KIND_INVALID);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      status_q <= '0;
      pos_q    <= '0;
      vel_q    <= '0;
      trq_q    <= '0;
      drv_q    <= '0;
      wnd_q    <= '0;
      time_q   <= '0;
      good_q   <= '0;
      bad_q    <= '0;
    end else begin
      if (take_fb) begin
        valid_q  <= 1'b1;
        status_q <= frame_i.status;
        pos_q    <= pos_i;
        vel_q    <= vel_i;
        trq_q    <= trq_i;
        drv_q    <= frame_i.drv_temp;
        wnd_q    <= frame_i.wnd_temp;
        time_q   <= frame_i.time_ms;
        good_q   <= good_q + CNT_W'(1);
      end
      if (take_bad) begin
        bad_q <= bad_q + CNT_W'(1);
      end
    end
  end

  assign have_feedback_o = valid_q;
  assign status_o        = status_q;
  assign pos_o           = pos_q;
  assign vel_o           = vel_q;
  assign trq_o           = trq_q;
  assign drv_temp_o      = drv_q;
  assign wnd_temp_o      = wnd_q;
  assign time_o          = time_q;
  assign good_o          = good_q;
  assign bad_o           = bad_q;

  `MFD_ASSERT_STD(a_good_step, take_fb |=> (good_q == $past(good_q) + CNT_W'(1)) && valid_q,
    "feedback frame did not bump the good count")
  `MFD_ASSERT_STD(a_foreign_quiet,
    (upd_i && (frame_i.kind == KIND_FOREIGN)) |=> $stable(good_q) && $stable(bad_q),
    "foreign frame changed a counter")
  `MFD_ASSERT_STD(a_bad_step, take_bad |=> (bad_q == $past(bad_q) + CNT_W'(1)) && $stable(time_q),
    "invalid frame did not bump only the invalid count")

endmodule

`default_nettype wire

FILE: hdl/motor_feedback_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder
// Classifies received CAN frames and decodes motor feedback into scaled
// position, velocity and torque with held status and frame counters.
// ----------------------------------------------------------------------------
// Each input item is one received frame; each frame yields exactly one output
// item carrying its kind and the held feedback state after that frame.
// The pipeline has three register stages: the input register, the scaling
// product register and the output register, through which each item passes
// in that order. One item per cycle is sustained while the receiver takes
// output items; the scaling multiply and the fold divider that follows each
// sit in a stage of their own.
// Each stage fills whenever it is empty, so items keep entering while an
// output item waits; once all stages hold items and the receiver stalls,
// s_axis_tready_o drops until the output item is taken.
// Reset empties the pipeline, clears the held state and counters and loads
// the register defaults. The register port is always ready and must only be
// written while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module motor_feedback_frame_decoder_core
  import mfd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned RATE_BITS     = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // frame_ident, frame_length, payload, time_ms
  input  wire logic [135:0] s_axis_tdata_i,
  // is_extended
  input  wire logic [0:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // have_feedback, motor_status, position_out, velocity_out, torque_out,
  // driver_temp, winding_temp, last_update_time, good_count, bad_count
  output logic [183:0]      m_axis_tdata_o,
  // frame_kind
  output logic [1:0]        m_axis_tuser_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [19:0]  cfg_data_i
);

  logic [SENDER_W-1:0] sender_q;
  logic [3:0]          motor_q;
  logic [LIMIT_W-1:0]  pos_lim_q;
  logic [LIMIT_W-1:0]  vel_lim_q;
  logic [LIMIT_W-1:0]  trq_lim_q;

  logic                v1_q;
  logic [IDENT_W-1:0]  ident_q;
  logic                ext_q;
  logic [3:0]          len_q;
  logic [63:0]         payload_q;
  logic [CNT_W-1:0]    time1_q;

  logic                v2_q;
  mfd_frame_t          frame2_q;
  mfd_frame_t          frame1;

  logic                out_v_q;
  logic [1:0]          kind_q;

  logic                out_ready;
  logic                st2_ready;
  logic                st1_ready;
  logic                move12;
  logic                move2o;

  logic signed [VALUE_W-1:0] pos_val, vel_val, trq_val;
  logic                      have_fb;
  logic [3:0]                status;
  logic signed [VALUE_W-1:0] pos_out, vel_out, trq_out;
  logic [7:0]                drv_temp, wnd_temp;
  logic [CNT_W-1:0]          upd_time, good_cnt, bad_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sender_q  <= '0;
      motor_q   <= 4'd1;
      pos_lim_q <= LIMIT_W'(12500);
      vel_lim_q <= LIMIT_W'(45000);
      trq_lim_q <= LIMIT_W'(18000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SENDER_ID: sender_q  <= cfg_data_i[SENDER_W-1:0];
        CFG_MOTOR_NUM: motor_q   <= cfg_data_i[3:0];
        CFG_POS_LIMIT: pos_lim_q <= cfg_data_i;
        CFG_VEL_LIMIT: vel_lim_q <= cfg_data_i;
        CFG_TRQ_LIMIT: trq_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready       = !out_v_q || m_axis_tready_i;
  assign st2_ready       = !v2_q || out_ready;
  assign st1_ready       = !v1_q || st2_ready;
  assign s_axis_tready_o = st1_ready;
  assign move12          = v1_q && st2_ready;
  assign move2o          = v2_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (st1_ready) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (st2_ready) begin
        v2_q <= v1_q;
      end
      if (out_ready) begin
        out_v_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && st1_ready) begin
      ident_q   <= s_axis_tdata_i[28:0];
      len_q     <= s_axis_tdata_i[32:29];
      payload_q <= s_axis_tdata_i[96:33];
      time1_q   <= s_axis_tdata_i[128:97];
      ext_q     <= s_axis_tuser_i[0];
    end
    if (move12) begin
      frame2_q <= frame1;
    end
    if (move2o) begin
      kind_q <= frame2_q.kind;
    end
  end

  always_comb begin
    frame1          = '0;
    frame1.status   = payload_q[63:60];
    frame1.drv_temp = payload_q[15:8];
    frame1.wnd_temp = payload_q[7:0];
    frame1.time_ms  = time1_q;
    if (ext_q || (ident_q != IDENT_W'(sender_q))) begin
      frame1.kind = KIND_FOREIGN;
    end else if ((len_q != 4'd8) || (payload_q[59:56] != motor_q)) begin
      frame1.kind = KIND_INVALID;
    end else begin
      frame1.kind = KIND_FEEDBACK;
    end
  end

  mfd_scale #(.BITS(POSITION_BITS)) u_pos (
    .clk_i   (clk_i),
    .load_i  (move12),
    .code_i  (payload_q[40 +: POSITION_BITS]),
    .limit_i (pos_lim_q),
    .value_o (pos_val)
  );

  mfd_scale #(.BITS(RATE_BITS)) u_vel (
    .clk_i   (clk_i),
    .load_i  (move12),
    .code_i  (payload_q[28 +: RATE_BITS]),
    .limit_i (vel_lim_q),
    .value_o (vel_val)
  );

  mfd_scale #(.BITS(RATE_BITS)) u_trq (
    .clk_i   (clk_i),
    .load_i  (move12),
    .code_i  (payload_q[16 +: RATE_BITS]),
    .limit_i (trq_lim_q),
    .value_o (trq_val)
  );

  mfd_state u_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_i           (move2o),
    .frame_i         (frame2_q),
    .pos_i           (pos_val),
    .vel_i           (vel_val),
    .trq_i           (trq_val),
    .have_feedback_o (have_fb),
    .status_o        (status),
    .pos_o           (pos_out),
    .vel_o           (vel_out),
    .trq_o           (trq_out),
    .drv_temp_o      (drv_temp),
    .wnd_temp_o      (wnd_temp),
    .time_o          (upd_time),
    .good_o          (good_cnt),
    .bad_o           (bad_cnt)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {4'b0000, bad_cnt, good_cnt, upd_time, wnd_temp, drv_temp,
                            trq_out, vel_out, pos_out, status, have_fb};

  `MFD_ASSERT_STD(a_fb_flag, (m_axis_tvalid_o && (m_axis_tuser_o == KIND_FEEDBACK)) |-> have_fb,
    "feedback item delivered without the feedback flag")
  `MFD_ASSERT_STD(a_pipe_hold, (v2_q && !out_ready) |=> v2_q && $stable(frame2_q),
    "frame left the scaling stage while the output was blocked")

endmodule

`default_nettype wire
